[rtl/pcx_rle_interlaced_line_decoder_defines.svh]
// Assertion macros for the PCX RLE interlaced line decoder.
// Used by the top level only; expects clk and rst_n in scope.
`ifndef PCX_RLE_INTERLACED_LINE_DECODER_DEFINES_SVH
`define PCX_RLE_INTERLACED_LINE_DECODER_DEFINES_SVH

// same-cycle implication, checked out of reset
`define PCXRLE_ASSERT_IMP(label, ante, cons) \
  label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
    else $error("pcxrle check failed");

// next-cycle implication, checked out of reset
`define PCXRLE_ASSERT_NXT(label, ante, cons) \
  label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
    else $error("pcxrle check failed");

`endif

[rtl/pcxrle_pkg.sv]
// Shared types and constants for the PCX RLE interlaced line decoder.
// No dependencies.
`timescale 1ns / 1ps

package pcxrle_pkg;

  localparam logic [7:0] KEY_MASK   = 8'hC0;
  localparam logic [5:0] COUNT_MASK = 6'h3F;

  // register reset values
  localparam logic [7:0]  RST_SCREEN_WIDTH = 8'd80;
  localparam logic [15:0] RST_DISPLAY_BASE = 16'd0;
  localparam logic [15:0] RST_ODD_OFFSET   = 16'd0;
  localparam logic [15:0] RST_START_COLUMN = 16'd0;
  localparam logic [9:0]  RST_START_LINE   = 10'd0;
  localparam logic [9:0]  RST_LINE_TOTAL   = 10'd0;
  localparam logic [11:0] RST_LINE_BYTES   = 12'd80;

  // first line address and parity under the reset register values
  localparam logic [15:0] RST_ROW_BASE  = 16'd0;
  localparam logic [15:0] RST_WRITE_PTR = 16'd0;
  localparam logic        RST_Y_ODD     = 1'b0;
  localparam logic        RST_FINISHED  = 1'b1;

  typedef enum logic [2:0] {
    REG_SCREEN_WIDTH = 3'd0,
    REG_DISPLAY_BASE = 3'd1,
    REG_ODD_OFFSET   = 3'd2,
    REG_START_COLUMN = 3'd3,
    REG_START_LINE   = 3'd4,
    REG_LINE_TOTAL   = 3'd5,
    REG_LINE_BYTES   = 3'd6
  } cfg_idx_t;

  typedef struct packed {
    logic [7:0]  screen_width;
    logic [15:0] display_base;
    logic [15:0] odd_field_offset;
    logic [15:0] start_column;
    logic [9:0]  start_line;
    logic [9:0]  line_total;
    logic [11:0] line_bytes;
  } cfg_t;

  // restart load for the decode state
  typedef struct packed {
    logic        load;
    logic [15:0] row_base;
    logic        y_odd;
    logic [15:0] write_ptr;
    logic        finished;
  } restart_t;

  typedef struct packed {
    logic [15:0] write_address;
    logic [7:0]  fill_value;
    logic [5:0]  fill_length;
    logic        line_done;
    logic        image_done;
  } result_t;

  typedef struct packed {
    logic finished;
    logic run_pending;
  } core_stat_t;

endpackage

[rtl/pcxrle_cfg.sv]
// Configuration registers and restart address computation.
// Depends on pcxrle_pkg.
`timescale 1ns / 1ps

module pcxrle_cfg
  import pcxrle_pkg::*;
(
  input  logic        clk,
  input  logic        rst_n,
  input  logic        cfg_write_en,
  input  logic [2:0]  cfg_index,
  input  logic [15:0] cfg_data,
  output cfg_t        cfg,
  output restart_t    restart
);

  cfg_t        cfg_r;
  cfg_t        cfg_nxt;
  logic        hit;
  logic [16:0] prod;
  logic [15:0] row_base;

  always_comb begin
    cfg_nxt = cfg_r;
    hit     = 1'b0;
    if (cfg_write_en) begin
      hit = 1'b1;
      case (cfg_idx_t'(cfg_index))
        REG_SCREEN_WIDTH: cfg_nxt.screen_width     = cfg_data[7:0];
        REG_DISPLAY_BASE: cfg_nxt.display_base     = cfg_data;
        REG_ODD_OFFSET:   cfg_nxt.odd_field_offset = cfg_data;
        REG_START_COLUMN: cfg_nxt.start_column     = cfg_data;
        REG_START_LINE:   cfg_nxt.start_line       = cfg_data[9:0];
        REG_LINE_TOTAL:   cfg_nxt.line_total       = cfg_data[9:0];
        REG_LINE_BYTES:   cfg_nxt.line_bytes       = cfg_data[11:0];
        default:          hit = 1'b0;
      endcase
    end
  end

  // first line: (start_line >> 1) * width + base + column, odd field offset if odd
  assign prod     = {8'd0, cfg_nxt.start_line[9:1]} * {9'd0, cfg_nxt.screen_width};
  assign row_base = prod[15:0] + cfg_nxt.display_base + cfg_nxt.start_column;

  always_comb begin
    restart.load      = hit;
    restart.row_base  = row_base;
    restart.y_odd     = cfg_nxt.start_line[0];
    restart.write_ptr = cfg_nxt.start_line[0] ? row_base + cfg_nxt.odd_field_offset
                                              : row_base;
    restart.finished  = (cfg_nxt.line_total == 10'd0);
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      cfg_r.screen_width     <= RST_SCREEN_WIDTH;
      cfg_r.display_base     <= RST_DISPLAY_BASE;
      cfg_r.odd_field_offset <= RST_ODD_OFFSET;
      cfg_r.start_column     <= RST_START_COLUMN;
      cfg_r.start_line       <= RST_START_LINE;
      cfg_r.line_total       <= RST_LINE_TOTAL;
      cfg_r.line_bytes       <= RST_LINE_BYTES;
    end else begin
      cfg_r <= cfg_nxt;
    end
  end

  assign cfg = cfg_r;

endmodule

[rtl/pcxrle_core.sv]
// Decode state and per-byte RLE decode: run key handling, line counting,
// incremental interlaced line addressing. Depends on pcxrle_pkg.
`timescale 1ns / 1ps

module pcxrle_core
  import pcxrle_pkg::*;
(
  input  logic       clk,
  input  logic       rst_n,
  input  cfg_t       cfg,
  input  restart_t   restart,
  input  logic       fire,
  input  logic [7:0] stream_byte,
  output logic       emit,
  output result_t    res,
  output core_stat_t stat
);

  logic        run_pending_r, run_pending_nxt;
  logic [5:0]  run_length_r,  run_length_nxt;
  logic [12:0] count_r,       count_nxt;
  logic [10:0] line_idx_r,    line_idx_nxt;
  logic [15:0] row_base_r,    row_base_nxt;
  logic        y_odd_r,       y_odd_nxt;
  logic [15:0] wptr_r,        wptr_nxt;
  logic        finished_r,    finished_nxt;

  logic [5:0]  len;
  logic [12:0] cnt_sum;
  logic [10:0] li_inc;
  logic [15:0] next_row;

  always_comb begin
    run_pending_nxt = run_pending_r;
    run_length_nxt  = run_length_r;
    count_nxt       = count_r;
    line_idx_nxt    = line_idx_r;
    row_base_nxt    = row_base_r;
    y_odd_nxt       = y_odd_r;
    wptr_nxt        = wptr_r;
    finished_nxt    = finished_r;
    emit            = 1'b0;
    len             = 6'd1;

    cnt_sum  = count_r + {7'd0, len};
    li_inc   = line_idx_r + 11'd1;
    // even to odd stays on the same half-line row, odd to even moves a row down
    next_row = y_odd_r ? row_base_r + {8'd0, cfg.screen_width} : row_base_r;

    res.write_address = wptr_r;
    res.fill_value    = stream_byte;
    res.fill_length   = len;
    res.line_done     = 1'b0;
    res.image_done    = 1'b0;

    if (fire && !finished_r) begin
      if (run_pending_r) begin
        run_pending_nxt = 1'b0;
        len             = run_length_r;
        emit            = (run_length_r != 6'd0);
      end else if ((stream_byte & KEY_MASK) == KEY_MASK) begin
        run_pending_nxt = 1'b1;
        run_length_nxt  = stream_byte[5:0] & COUNT_MASK;
      end else begin
        emit = 1'b1;
      end
    end

    cnt_sum         = count_r + {7'd0, len};
    res.fill_length = len;

    if (emit) begin
      wptr_nxt  = wptr_r + {10'd0, len};
      count_nxt = cnt_sum;
      if (cnt_sum >= {1'b0, cfg.line_bytes}) begin
        res.line_done = 1'b1;
        count_nxt     = 13'd0;
        line_idx_nxt  = li_inc;
        if (li_inc >= {1'b0, cfg.line_total}) begin
          finished_nxt   = 1'b1;
          res.image_done = 1'b1;
        end else begin
          row_base_nxt = next_row;
          y_odd_nxt    = !y_odd_r;
          wptr_nxt     = y_odd_r ? next_row : next_row + cfg.odd_field_offset;
        end
      end
    end

    // register write restarts the decoder
    if (restart.load) begin
      run_pending_nxt = 1'b0;
      run_length_nxt  = 6'd0;
      count_nxt       = 13'd0;
      line_idx_nxt    = 11'd0;
      row_base_nxt    = restart.row_base;
      y_odd_nxt       = restart.y_odd;
      wptr_nxt        = restart.write_ptr;
      finished_nxt    = restart.finished;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      run_pending_r <= 1'b0;
      run_length_r  <= 6'd0;
      count_r       <= 13'd0;
      line_idx_r    <= 11'd0;
      row_base_r    <= RST_ROW_BASE;
      y_odd_r       <= RST_Y_ODD;
      wptr_r        <= RST_WRITE_PTR;
      finished_r    <= RST_FINISHED;
    end else begin
      run_pending_r <= run_pending_nxt;
      run_length_r  <= run_length_nxt;
      count_r       <= count_nxt;
      line_idx_r    <= line_idx_nxt;
      row_base_r    <= row_base_nxt;
      y_odd_r       <= y_odd_nxt;
      wptr_r        <= wptr_nxt;
      finished_r    <= finished_nxt;
    end
  end

  assign stat.finished    = finished_r;
  assign stat.run_pending = run_pending_r;

endmodule

[rtl/pcx_rle_interlaced_line_decoder.sv]
// PCX RLE decoder to interlaced display fill commands.
// Path: accepted byte in the input register, then its fill in the output register.
// Throughput: one byte per cycle, bounded by the single decode stage between the
// input register and the output register; stalls only when the output is held.
// Reset (synchronous, rst_n low): registers to defaults, decoder finished, no beats.
`timescale 1ns / 1ps
`include "pcx_rle_interlaced_line_decoder_defines.svh"

module pcx_rle_interlaced_line_decoder
  import pcxrle_pkg::*;
(
  input  logic        clk,
  input  logic        rst_n,
  input  logic        cfg_write_en,
  input  logic [2:0]  cfg_index,
  input  logic [15:0] cfg_data,
  input  logic        in_valid,
  output logic        in_stall,
  input  logic [7:0]  in_stream_byte,
  output logic        out_valid,
  input  logic        out_stall,
  output logic [15:0] out_write_address,
  output logic [7:0]  out_fill_value,
  output logic [5:0]  out_fill_length,
  output logic        out_line_done,
  output logic        out_image_done
);

  cfg_t       cfg;
  restart_t   restart;
  result_t    res;
  core_stat_t stat;
  logic       emit;

  logic       s1_valid_r;
  logic [7:0] s1_byte_r;
  logic       out_valid_r;
  result_t    out_r;
  logic       out_free;
  logic       s1_adv;
  logic       in_fire;

  assign out_free = !out_valid_r || !out_stall;
  assign s1_adv   = s1_valid_r && out_free;
  assign in_stall = s1_valid_r && !out_free;
  assign in_fire  = in_valid && !in_stall;

  pcxrle_cfg u_cfg (
    .clk          (clk),
    .rst_n        (rst_n),
    .cfg_write_en (cfg_write_en),
    .cfg_index    (cfg_index),
    .cfg_data     (cfg_data),
    .cfg          (cfg),
    .restart      (restart)
  );

  pcxrle_core u_core (
    .clk         (clk),
    .rst_n       (rst_n),
    .cfg         (cfg),
    .restart     (restart),
    .fire        (s1_adv),
    .stream_byte (s1_byte_r),
    .emit        (emit),
    .res         (res),
    .stat        (stat)
  );

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      s1_valid_r <= 1'b0;
    end else if (in_fire) begin
      s1_valid_r <= 1'b1;
    end else if (s1_adv) begin
      s1_valid_r <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (in_fire) begin
      s1_byte_r <= in_stream_byte;
    end
  end

  // output slot is free whenever the decode stage advances
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      out_valid_r <= 1'b0;
    end else if (emit) begin
      out_valid_r <= 1'b1;
    end else if (!out_stall) begin
      out_valid_r <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (emit) begin
      out_r <= res;
    end
  end

  assign out_valid         = out_valid_r;
  assign out_write_address = out_r.write_address;
  assign out_fill_value    = out_r.fill_value;
  assign out_fill_length   = out_r.fill_length;
  assign out_line_done     = out_r.line_done;
  assign out_image_done    = out_r.image_done;

  `PCXRLE_ASSERT_IMP(a_len_nonzero, out_valid_r, out_r.fill_length != 6'd0)
  `PCXRLE_ASSERT_IMP(a_image_ends_line, out_valid_r && out_r.image_done, out_r.line_done)
  `PCXRLE_ASSERT_NXT(a_idle_when_done, s1_adv && stat.finished, !out_valid_r)

endmodule

[tb/tb.sv]
// Self-checking bench for pcx_rle_interlaced_line_decoder: random bursts of stream bytes
// against an in-bench decoder model, with random output back-pressure.
// Depends on pcxrle_pkg and the decoder RTL only.
`timescale 1ns / 1ps

module tb;
  import pcxrle_pkg::*;

  localparam int          CYCLE_LIMIT = 300000;
  localparam int          BYTE_TARGET = 700;
  localparam logic [2:0]  REG_SPARE   = 3'd7;  // past the register list, must be ignored

  logic        clk = 1'b0;
  logic        rst_n = 1'b0;
  logic        cfg_write_en = 1'b0;
  logic [2:0]  cfg_index = '0;
  logic [15:0] cfg_data = '0;
  logic        in_valid = 1'b0;
  logic        in_stall;
  logic [7:0]  in_stream_byte = '0;
  logic        out_valid;
  logic        out_stall = 1'b0;
  logic [15:0] out_write_address;
  logic [7:0]  out_fill_value;
  logic [5:0]  out_fill_length;
  logic        out_line_done;
  logic        out_image_done;

  pcx_rle_interlaced_line_decoder u_dut (
    .clk               (clk),
    .rst_n             (rst_n),
    .cfg_write_en      (cfg_write_en),
    .cfg_index         (cfg_index),
    .cfg_data          (cfg_data),
    .in_valid          (in_valid),
    .in_stall          (in_stall),
    .in_stream_byte    (in_stream_byte),
    .out_valid         (out_valid),
    .out_stall         (out_stall),
    .out_write_address (out_write_address),
    .out_fill_value    (out_fill_value),
    .out_fill_length   (out_fill_length),
    .out_line_done     (out_line_done),
    .out_image_done    (out_image_done)
  );

  always begin
    #4 clk = 1'b1;
    #4 clk = 1'b0;
  end

  // ---------------- decoder model ----------------
  cfg_t        shadow_regs;
  logic        dec_run_pending;
  logic [5:0]  dec_run_len;
  logic [12:0] dec_count;
  logic [10:0] dec_line;
  logic [15:0] dec_wptr;
  logic        dec_finished;

  result_t     fill_expect[$];
  logic [7:0]  stream_bytes[$];

  int mismatches   = 0;
  int bytes_seen   = 0;
  int bytes_live   = 0;
  int fills_seen   = 0;
  int lines_seen   = 0;
  int images_seen  = 0;
  int setups       = 0;
  int cycles       = 0;

  // interlaced start address of image line start_line + idx
  function automatic logic [15:0] row_start(logic [10:0] idx);
    logic [10:0] y;
    logic [31:0] a;
    y = {1'b0, shadow_regs.start_line} + idx;
    a = 32'(y >> 1) * shadow_regs.screen_width + shadow_regs.display_base
        + shadow_regs.start_column;
    if (y[0]) a = a + shadow_regs.odd_field_offset;
    return a[15:0];
  endfunction

  task automatic restart_decoder();
    dec_run_pending = 1'b0;
    dec_run_len     = '0;
    dec_count       = '0;
    dec_line        = '0;
    dec_wptr        = row_start('0);
    dec_finished    = (shadow_regs.line_total == '0);
  endtask

  task automatic decoder_reset();
    shadow_regs = '{screen_width: RST_SCREEN_WIDTH, display_base: RST_DISPLAY_BASE,
                    odd_field_offset: RST_ODD_OFFSET, start_column: RST_START_COLUMN,
                    start_line: RST_START_LINE, line_total: RST_LINE_TOTAL,
                    line_bytes: RST_LINE_BYTES};
    restart_decoder();
  endtask

  task automatic apply_reg(logic [2:0] idx, logic [15:0] d);
    case (idx)
      REG_SCREEN_WIDTH: shadow_regs.screen_width     = d[7:0];
      REG_DISPLAY_BASE: shadow_regs.display_base     = d;
      REG_ODD_OFFSET:   shadow_regs.odd_field_offset = d;
      REG_START_COLUMN: shadow_regs.start_column     = d;
      REG_START_LINE:   shadow_regs.start_line       = d[9:0];
      REG_LINE_TOTAL:   shadow_regs.line_total       = d[9:0];
      REG_LINE_BYTES:   shadow_regs.line_bytes       = d[11:0];
      default:          return;
    endcase
    restart_decoder();
  endtask

  task automatic decode_byte(logic [7:0] b);
    logic [5:0] len;
    result_t    r;
    if (dec_finished) return;
    bytes_live++;
    if (dec_run_pending) begin
      dec_run_pending = 1'b0;
      len = dec_run_len;
      if (len == '0) return;  // zero-length run swallows its value byte
    end else if ((b & KEY_MASK) == KEY_MASK) begin
      dec_run_pending = 1'b1;
      dec_run_len     = b[5:0] & COUNT_MASK;
      return;
    end else begin
      len = 6'd1;
    end
    r.write_address = dec_wptr;
    r.fill_value    = b;
    r.fill_length   = len;
    r.line_done     = 1'b0;
    r.image_done    = 1'b0;
    dec_wptr  = dec_wptr + 16'(len);
    dec_count = dec_count + 13'(len);
    // overshoot is not clipped; the next line restarts at its own address
    if (dec_count >= {1'b0, shadow_regs.line_bytes}) begin
      r.line_done = 1'b1;
      dec_count   = '0;
      dec_line    = dec_line + 11'd1;
      if (dec_line >= {1'b0, shadow_regs.line_total}) begin
        dec_finished = 1'b1;
        r.image_done = 1'b1;
      end else begin
        dec_wptr = row_start(dec_line);
      end
    end
    fill_expect.push_back(r);
  endtask

  // ---------------- checking ----------------
  task automatic log_mismatch(string msg);
    $display("MISMATCH t=%0t: %s", $time, msg);
    mismatches++;
  endtask

  task automatic check_field(string name, logic [15:0] got, logic [15:0] want);
    if (got !== want)
      log_mismatch($sformatf("beat %0d %s got 0x%0h want 0x%0h", fills_seen, name, got, want));
  endtask

  logic byte_accepted = 1'b0;

  always @(posedge clk) begin
    result_t want;
    byte_accepted <= in_valid && !in_stall;
    if (!rst_n) begin
      decoder_reset();
    end else begin
      if (cfg_write_en) apply_reg(cfg_index, cfg_data);
      if (in_valid && !in_stall) begin
        bytes_seen++;
        decode_byte(in_stream_byte);
      end
      if (out_valid && !out_stall) begin
        if (fill_expect.size() == 0) begin
          log_mismatch($sformatf("unexpected fill beat addr 0x%0h value 0x%0h",
                                 out_write_address, out_fill_value));
        end else begin
          want = fill_expect.pop_front();
          check_field("write_address", out_write_address, want.write_address);
          check_field("fill_value", 16'(out_fill_value), 16'(want.fill_value));
          check_field("fill_length", 16'(out_fill_length), 16'(want.fill_length));
          check_field("line_done", 16'(out_line_done), 16'(want.line_done));
          check_field("image_done", 16'(out_image_done), 16'(want.image_done));
          if (want.line_done) lines_seen++;
          if (want.image_done) images_seen++;
        end
        fills_seen++;
      end
    end
  end

  always @(posedge clk) begin
    cycles++;
    if (cycles == CYCLE_LIMIT) begin
      $display("timeout after %0d cycles, %0d fills still expected", cycles, fill_expect.size());
      $display("[FAIL] regression broken");
      $finish;
    end
  end

  // ---------------- stream driver ----------------
  int burst_left = 1;
  int gap_left   = 0;

  always @(negedge clk) begin
    if (rst_n && (!in_valid || byte_accepted)) begin
      if (gap_left > 0 || stream_bytes.size() == 0) begin
        in_valid <= 1'b0;
        if (gap_left > 0) gap_left--;
      end else begin
        in_valid       <= 1'b1;
        in_stream_byte <= stream_bytes.pop_front();
        if (burst_left > 1) begin
          burst_left--;
        end else begin
          burst_left = $urandom_range(1, 24);
          gap_left   = ($urandom_range(0, 2) == 0) ? 0 : $urandom_range(1, 6);
        end
      end
    end
  end

  // ---------------- output back-pressure ----------------
  int hold_tick = 0;
  int hold_mode = 0;

  always @(negedge clk) begin
    hold_tick++;
    if (hold_tick % 48 == 0) hold_mode = $urandom_range(0, 3);
    case (hold_mode)
      0:       out_stall <= 1'b0;
      1:       out_stall <= ($urandom_range(0, 3) == 0);
      2:       out_stall <= ($urandom_range(0, 3) != 0);
      default: out_stall <= (hold_tick % 3 == 1);
    endcase
  end

  // ---------------- stimulus ----------------
  task automatic wait_idle();
    do begin
      @(posedge clk);
      #1;
    end while (stream_bytes.size() != 0 || in_valid || fill_expect.size() != 0);
    // trailing bytes that make no fill may still be in the pipe
    repeat (6) @(posedge clk);
  endtask

  task automatic load_setup(cfg_t c);
    logic [15:0] pad;
    logic [15:0] word;
    for (int i = 0; i < 7; i++) begin
      pad = 16'($urandom);
      case (cfg_idx_t'(i))
        REG_SCREEN_WIDTH: word = {pad[15:8], c.screen_width};
        REG_DISPLAY_BASE: word = c.display_base;
        REG_ODD_OFFSET:   word = c.odd_field_offset;
        REG_START_COLUMN: word = c.start_column;
        REG_START_LINE:   word = {pad[15:10], c.start_line};
        REG_LINE_TOTAL:   word = {pad[15:10], c.line_total};
        default:          word = {pad[15:12], c.line_bytes};
      endcase
      @(negedge clk);
      cfg_write_en <= 1'b1;
      cfg_index    <= i[2:0];
      cfg_data     <= word;
    end
    @(negedge clk);
    cfg_write_en <= 1'b0;
    setups++;
  endtask

  // mostly literals and key/value pairs, some raw noise
  task automatic queue_random_bytes(int n);
    int sel;
    for (int i = 0; i < n; i++) begin
      sel = $urandom_range(0, 9);
      if (sel < 6) begin
        stream_bytes.push_back(8'($urandom_range(0, 8'hBF)));
      end else if (sel < 9) begin
        stream_bytes.push_back(KEY_MASK | 8'($urandom_range(0, 63)));
        stream_bytes.push_back(8'($urandom));
      end else begin
        stream_bytes.push_back(8'($urandom));
      end
    end
  endtask

  initial begin
    cfg_t setup;
    int   phase;
    repeat (4) @(negedge clk);
    rst_n <= 1'b1;

    // reset setup has zero lines: everything is dropped
    stream_bytes = '{8'h41, 8'hC5, 8'h10};
    wait_idle();

    setup = '{screen_width: 8'd4, display_base: 16'h0100, odd_field_offset: 16'h8000,
              start_column: 16'd3, start_line: 10'd1, line_total: 10'd3, line_bytes: 12'd5};
    load_setup(setup);
    // literal low/high, zero run with key-looking value, short run, line end,
    // max run overshooting a line
    stream_bytes = '{8'h00, 8'hBF, 8'hC0, 8'hFF, 8'hC2, 8'hC7, 8'h7F, 8'hFF, 8'h80};
    wait_idle();
    // write past the register list mid-image: no restart
    @(negedge clk);
    cfg_write_en <= 1'b1;
    cfg_index    <= REG_SPARE;
    cfg_data     <= 16'($urandom);
    @(negedge clk);
    cfg_write_en <= 1'b0;
    // finish the image, then bytes after it are ignored
    stream_bytes = '{8'hC1, 8'h00, 8'hC4, 8'h55, 8'h33, 8'hC3};
    wait_idle();

    // zero line length: each write ends its line
    setup = '{screen_width: 8'd255, display_base: 16'hFFF0, odd_field_offset: 16'h0040,
              start_column: 16'h0020, start_line: 10'd0, line_total: 10'd2, line_bytes: 12'd0};
    load_setup(setup);
    stream_bytes = '{8'h01, 8'hC9, 8'h02, 8'h03};
    wait_idle();

    phase = 0;
    while (bytes_seen < BYTE_TARGET && phase < 60) begin
      case (phase)
        0: setup = '{screen_width: 8'hFF, display_base: 16'hFFFF, odd_field_offset: 16'hFFFF,
                     start_column: 16'hFFFF, start_line: 10'h3FF, line_total: 10'h3FF,
                     line_bytes: 12'hFFF};
        1: setup = '{screen_width: 8'h00, display_base: 16'h0000, odd_field_offset: 16'h0000,
                     start_column: 16'h0000, start_line: 10'h000, line_total: 10'd1,
                     line_bytes: 12'd1};
        2: setup = '{screen_width: 8'hFF, display_base: 16'hFFFF, odd_field_offset: 16'h1234,
                     start_column: 16'h8000, start_line: 10'h3FF, line_total: 10'h3FF,
                     line_bytes: 12'd1};
        default: begin
          setup.screen_width     = 8'($urandom);
          setup.display_base     = 16'($urandom);
          setup.odd_field_offset = 16'($urandom);
          setup.start_column     = 16'($urandom);
          setup.start_line       = 10'($urandom);
          setup.line_total       = 10'($urandom_range(1, 30));
          setup.line_bytes       = ($urandom_range(0, 7) == 0) ? 12'($urandom_range(64, 300))
                                                                : 12'($urandom_range(1, 32));
        end
      endcase
      load_setup(setup);
      queue_random_bytes($urandom_range(40, 110));
      wait_idle();
      phase++;
    end

    $display("covered %0d stream bytes (%0d before image end) across %0d register setups",
             bytes_seen, bytes_live, setups);
    $display("checked %0d fill beats: %0d line ends, %0d image ends; %0d mismatches",
             fills_seen, lines_seen, images_seen, mismatches);
    if (mismatches == 0) begin
      $display("[ OK ] regression clean");
    end else begin
      $display("[FAIL] regression broken");
    end
    $finish;
  end

endmodule
